// ===== hw/rtl/pbpm_pkg.sv =====
package pbpm_pkg;

    localparam int SLOTS    = 1024;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int SIDX_W   = SLOT_W + 1;
    localparam int PIN_BITS = 16;
    localparam int ID_W     = 32;
    localparam int STAT_W   = 3;

    localparam logic [SIDX_W-1:0]   NO_SLOT  = SIDX_W'(SLOTS);
    localparam logic [SIDX_W-1:0]   SENTINEL = SIDX_W'(SLOTS);
    localparam logic [PIN_BITS-1:0] PIN_MAX  = {PIN_BITS{1'b1}};
    localparam logic [PIN_BITS-1:0] PIN_ONE  = PIN_BITS'(1);

    localparam logic [2:0] REQ_GET     = 3'd0;
    localparam logic [2:0] REQ_GET_WR  = 3'd1;
    localparam logic [2:0] REQ_MAKE_WR = 3'd2;
    localparam logic [2:0] REQ_RELEASE = 3'd3;
    localparam logic [2:0] REQ_ALLOC   = 3'd4;
    localparam logic [2:0] REQ_DELETE  = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_WR_LOCK  = 3'd1;
    localparam logic [STAT_W-1:0] ST_PINS     = 3'd2;
    localparam logic [STAT_W-1:0] ST_NO_EVICT = 3'd3;
    localparam logic [STAT_W-1:0] ST_BAD_ID   = 3'd4;
    localparam logic [STAT_W-1:0] ST_NOT_HELD = 3'd5;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREE_HEAD  = 1'b1;

    // first member sits in the highest bits
    typedef struct packed {
        logic [ID_W-1:0]   next_free_id;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   page_id;
        logic [2:0]        req_type;
    } pbpm_req_t;

    typedef struct packed {
        logic [ID_W-1:0]     page_count;
        logic [ID_W-1:0]     free_head;
        logic [PIN_BITS-1:0] pin_count;
        logic [ID_W-1:0]     link_to_store;
        logic                header_write;
        logic                write_back;
        logic                append_to_file;
        logic                fill_from_disk;
        logic [ID_W-1:0]     result_page_id;
        logic [SLOT_W-1:0]   result_slot;
        logic [STAT_W-1:0]   status;
    } pbpm_result_t;

    localparam int REQ_W     = $bits(pbpm_req_t);
    localparam int RES_W     = $bits(pbpm_result_t);
    localparam int IN_DATA_W  = ((REQ_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;

    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_DISP,
        S_F_BKT,
        S_F_HEAD,
        S_F_CMP,
        S_G_HIT,
        S_A_HIT,
        S_HC,
        S_TAKE,
        S_LR_RD,
        S_LR_W,
        S_LA1,
        S_LA2,
        S_MR_RD,
        S_MR_B,
        S_MR_BW,
        S_MR_WALK,
        S_TK_INIT,
        S_MA_W,
        S_FIN,
        S_OUT
    } pbpm_state_t;

endpackage

// ===== hw/rtl/pbpm_core.sv =====
module pbpm_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [pbpm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pbpm_pkg::ID_W-1:0]   cfg_data,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  pbpm_pkg::pbpm_req_t         req,
    output logic                        res_valid,
    input  logic                        res_ready,
    output pbpm_pkg::pbpm_result_t      res
);
    import pbpm_pkg::*;

    // directory memories
    logic [ID_W-1:0]     pid_mem   [SLOTS];
    logic [PIN_BITS-1:0] pin_mem   [SLOTS];
    logic                wr_mem    [SLOTS];
    logic [SIDX_W-1:0]   chain_mem [SLOTS];
    logic [SIDX_W-1:0]   bkt_mem   [SLOTS];
    logic [SIDX_W-1:0]   lnext_mem [SLOTS];
    logic [SIDX_W-1:0]   lprev_mem [SLOTS];

    logic [SLOT_W-1:0]   pid_ra, pin_ra, wr_ra, chain_ra, bkt_ra, lru_ra;
    logic [SLOT_W-1:0]   pid_wa, pin_wa, wr_wa, chain_wa, bkt_wa, lnext_wa, lprev_wa;
    logic                pid_we, pin_we, wr_we, chain_we, bkt_we, lnext_we, lprev_we;
    logic [ID_W-1:0]     pid_wd, pid_rd;
    logic [PIN_BITS-1:0] pin_wd, pin_rd;
    logic                wr_wd, wr_rd;
    logic [SIDX_W-1:0]   chain_wd, chain_rd, bkt_wd, bkt_rd;
    logic [SIDX_W-1:0]   lnext_wd, lnext_rd, lprev_wd, lprev_rd;

    pbpm_state_t         state_reg, state_next;
    pbpm_req_t           req_reg, req_next;
    logic [SIDX_W-1:0]   cur_reg, cur_next;
    logic [SIDX_W-1:0]   rslot_reg, rslot_next;
    logic [SIDX_W-1:0]   p_reg, p_next;
    logic [SIDX_W-1:0]   cs_reg, cs_next;
    logic [SLOT_W-1:0]   bkt_reg, bkt_next;
    logic [ID_W-1:0]     key_reg, key_next;
    logic [STAT_W-1:0]   status_reg, status_next;
    logic                fill_reg, fill_next;
    logic                append_reg, append_next;
    logic                wback_reg, wback_next;
    logic                hdr_reg, hdr_next;
    logic [ID_W-1:0]     link_reg, link_next;
    logic [ID_W-1:0]     free_head_reg, free_head_next;
    logic [ID_W-1:0]     page_count_reg, page_count_next;
    logic [SIDX_W-1:0]   used_reg, used_next;
    logic [SIDX_W-1:0]   head_reg, head_next;
    logic [SIDX_W-1:0]   tail_reg, tail_next;
    logic [SIDX_W-1:0]   clr_reg, clr_next;
    logic                in_take_reg, in_take_next;

    logic                is_get, is_held_op, bad_get, sin_out, hit, pool_room;
    logic [PIN_BITS-1:0] pin_inc;
    logic [SIDX_W-1:0]   sin_ext;

    always_ff @(posedge clk)
    begin
        if (pid_we)
        begin
            pid_mem[pid_wa] <= pid_wd;
        end
        if (pin_we)
        begin
            pin_mem[pin_wa] <= pin_wd;
        end
        if (wr_we)
        begin
            wr_mem[wr_wa] <= wr_wd;
        end
        if (chain_we)
        begin
            chain_mem[chain_wa] <= chain_wd;
        end
        if (bkt_we)
        begin
            bkt_mem[bkt_wa] <= bkt_wd;
        end
        if (lnext_we)
        begin
            lnext_mem[lnext_wa] <= lnext_wd;
        end
        if (lprev_we)
        begin
            lprev_mem[lprev_wa] <= lprev_wd;
        end
        pid_rd   <= pid_mem[pid_ra];
        pin_rd   <= pin_mem[pin_ra];
        wr_rd    <= wr_mem[wr_ra];
        chain_rd <= chain_mem[chain_ra];
        bkt_rd   <= bkt_mem[bkt_ra];
        lnext_rd <= lnext_mem[lru_ra];
        lprev_rd <= lprev_mem[lru_ra];
    end

    assign is_get     = (req_reg.req_type == REQ_GET) || (req_reg.req_type == REQ_GET_WR);
    assign is_held_op = (req_reg.req_type == REQ_MAKE_WR) || (req_reg.req_type == REQ_RELEASE)
                        || (req_reg.req_type == REQ_DELETE);
    assign bad_get    = (req_reg.page_id == '0) || (req_reg.page_id >= page_count_reg);
    assign sin_ext    = {1'b0, req_reg.slot};
    assign sin_out    = sin_ext >= used_reg;
    assign hit        = pid_rd == key_reg;
    assign pool_room  = used_reg < SIDX_W'(SLOTS);
    assign pin_inc    = (pin_rd == PIN_MAX) ? pin_rd : pin_rd + PIN_ONE;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:
            begin
                if (clr_reg == SIDX_W'(SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                priority if (is_get)
                begin
                    state_next = bad_get ? S_FIN : S_F_BKT;
                end
                else if (is_held_op)
                begin
                    state_next = sin_out ? S_FIN : S_HC;
                end
                else if (req_reg.req_type == REQ_ALLOC)
                begin
                    priority if (free_head_reg != '0)
                    begin
                        state_next = S_F_BKT;
                    end
                    else if ((page_count_reg == '0) || (page_count_reg == '1))
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_TAKE;
                    end
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_F_BKT:   state_next = S_F_HEAD;
            S_F_HEAD:  state_next = (bkt_rd == NO_SLOT) ? S_TAKE : S_F_CMP;
            S_F_CMP:
            begin
                priority if (hit)
                begin
                    state_next = is_get ? S_G_HIT : S_A_HIT;
                end
                else if (chain_rd == NO_SLOT)
                begin
                    state_next = S_TAKE;
                end
                else
                begin
                    state_next = S_F_CMP;
                end
            end
            S_G_HIT:
            begin
                state_next = (!wr_rd && pin_rd == '0) ? S_LR_RD : S_FIN;
            end
            S_A_HIT:   state_next = (pin_rd == '0) ? S_LR_RD : S_FIN;
            S_HC:
            begin
                priority if (pin_rd == '0)
                begin
                    state_next = S_FIN;
                end
                else if (req_reg.req_type == REQ_RELEASE)
                begin
                    state_next = (pin_rd == PIN_ONE) ? S_LA1 : S_FIN;
                end
                else if (req_reg.req_type == REQ_DELETE && pin_rd == PIN_ONE)
                begin
                    state_next = S_LA1;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_TAKE:
            begin
                priority if (pool_room)
                begin
                    state_next = S_TK_INIT;
                end
                else if (tail_reg == SENTINEL)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_LR_RD;
                end
            end
            S_LR_RD:   state_next = S_LR_W;
            S_LR_W:    state_next = in_take_reg ? S_MR_RD : S_FIN;
            S_LA1:     state_next = S_LA2;
            S_LA2:     state_next = S_FIN;
            S_MR_RD:   state_next = S_MR_B;
            S_MR_B:    state_next = S_MR_BW;
            S_MR_BW:
            begin
                state_next = (bkt_rd == cur_reg || bkt_rd == NO_SLOT) ? S_TK_INIT : S_MR_WALK;
            end
            S_MR_WALK:
            begin
                if (chain_rd == cur_reg || chain_rd == NO_SLOT)
                begin
                    state_next = S_TK_INIT;
                end
            end
            S_TK_INIT: state_next = S_MA_W;
            S_MA_W:    state_next = S_FIN;
            S_FIN:     state_next = S_OUT;
            S_OUT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        req_next        = req_reg;
        cur_next        = cur_reg;
        rslot_next      = rslot_reg;
        p_next          = p_reg;
        cs_next         = cs_reg;
        bkt_next        = bkt_reg;
        key_next        = key_reg;
        status_next     = status_reg;
        fill_next       = fill_reg;
        append_next     = append_reg;
        wback_next      = wback_reg;
        hdr_next        = hdr_reg;
        link_next       = link_reg;
        free_head_next  = free_head_reg;
        page_count_next = page_count_reg;
        used_next       = used_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        clr_next        = clr_reg;
        in_take_next    = in_take_reg;
        req_ready       = 1'b0;
        res_valid       = 1'b0;

        pid_ra   = cur_reg[SLOT_W-1:0];
        pin_ra   = cur_reg[SLOT_W-1:0];
        wr_ra    = cur_reg[SLOT_W-1:0];
        chain_ra = cur_reg[SLOT_W-1:0];
        bkt_ra   = key_reg[SLOT_W-1:0];
        lru_ra   = cur_reg[SLOT_W-1:0];

        pid_we   = 1'b0;  pid_wa   = cur_reg[SLOT_W-1:0];  pid_wd   = key_reg;
        pin_we   = 1'b0;  pin_wa   = cur_reg[SLOT_W-1:0];  pin_wd   = PIN_ONE;
        wr_we    = 1'b0;  wr_wa    = cur_reg[SLOT_W-1:0];  wr_wd    = 1'b0;
        chain_we = 1'b0;  chain_wa = cur_reg[SLOT_W-1:0];  chain_wd = bkt_rd;
        bkt_we   = 1'b0;  bkt_wa   = key_reg[SLOT_W-1:0];  bkt_wd   = cur_reg;
        lnext_we = 1'b0;  lnext_wa = cur_reg[SLOT_W-1:0];  lnext_wd = head_reg;
        lprev_we = 1'b0;  lprev_wa = cur_reg[SLOT_W-1:0];  lprev_wd = SENTINEL;

        unique case (state_reg)
            S_CLR:
            begin
                bkt_we   = 1'b1;
                bkt_wa   = clr_reg[SLOT_W-1:0];
                bkt_wd   = NO_SLOT;
                clr_next = clr_reg + SIDX_W'(1);
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    req_next     = req;
                    rslot_next   = NO_SLOT;
                    status_next  = ST_OK;
                    fill_next    = 1'b0;
                    append_next  = 1'b0;
                    wback_next   = 1'b0;
                    hdr_next     = 1'b0;
                    link_next    = '0;
                    in_take_next = 1'b0;
                end
            end
            S_DISP:
            begin
                pid_ra = req_reg.slot;
                pin_ra = req_reg.slot;
                wr_ra  = req_reg.slot;
                priority if (is_get)
                begin
                    key_next = req_reg.page_id;
                    if (bad_get)
                    begin
                        status_next = ST_BAD_ID;
                    end
                end
                else if (is_held_op)
                begin
                    cur_next = sin_ext;
                    if (sin_out)
                    begin
                        status_next = ST_NOT_HELD;
                    end
                end
                else if (req_reg.req_type == REQ_ALLOC)
                begin
                    priority if (free_head_reg != '0)
                    begin
                        key_next = free_head_reg;
                    end
                    else if ((page_count_reg == '0) || (page_count_reg == '1))
                    begin
                        status_next = ST_BAD_ID;
                    end
                    else
                    begin
                        key_next = page_count_reg;
                    end
                end
                else
                begin
                    status_next = ST_OK;
                end
            end
            S_F_BKT:
            begin
                bkt_ra = key_reg[SLOT_W-1:0];
            end
            S_F_HEAD:
            begin
                cur_next = bkt_rd;
                pid_ra   = bkt_rd[SLOT_W-1:0];
                chain_ra = bkt_rd[SLOT_W-1:0];
            end
            S_F_CMP:
            begin
                if (!hit)
                begin
                    cur_next = chain_rd;
                    pid_ra   = chain_rd[SLOT_W-1:0];
                    chain_ra = chain_rd[SLOT_W-1:0];
                end
            end
            S_G_HIT:
            begin
                rslot_next = cur_reg;
                priority if (wr_rd)
                begin
                    status_next = ST_WR_LOCK;
                end
                else if (pin_rd == '0)
                begin
                    pin_we = 1'b1;
                    pin_wd = PIN_ONE;
                    if (req_reg.req_type == REQ_GET_WR)
                    begin
                        wr_we = 1'b1;
                        wr_wd = 1'b1;
                    end
                end
                else
                begin
                    pin_we = 1'b1;
                    if (req_reg.req_type == REQ_GET_WR)
                    begin
                        pin_wd      = pin_inc - PIN_ONE;
                        status_next = ST_PINS;
                    end
                    else
                    begin
                        pin_wd = pin_inc;
                    end
                end
            end
            S_A_HIT:
            begin
                rslot_next = cur_reg;
                if (pin_rd != '0)
                begin
                    status_next = ST_PINS;
                end
                else
                begin
                    pin_we         = 1'b1;
                    pin_wd         = PIN_ONE;
                    wr_we          = 1'b1;
                    wr_wd          = 1'b1;
                    free_head_next = req_reg.next_free_id;
                end
            end
            S_HC:
            begin
                priority if (pin_rd == '0)
                begin
                    status_next = ST_NOT_HELD;
                end
                else if (req_reg.req_type == REQ_RELEASE)
                begin
                    rslot_next = cur_reg;
                    pin_we     = 1'b1;
                    pin_wd     = pin_rd - PIN_ONE;
                    if (wr_rd)
                    begin
                        wr_we      = 1'b1;
                        wr_wd      = 1'b0;
                        wback_next = 1'b1;
                    end
                end
                else if (pin_rd != PIN_ONE)
                begin
                    rslot_next  = cur_reg;
                    status_next = ST_PINS;
                end
                else if (req_reg.req_type == REQ_MAKE_WR)
                begin
                    rslot_next = cur_reg;
                    wr_we      = 1'b1;
                    wr_wd      = 1'b1;
                end
                else
                begin
                    rslot_next     = cur_reg;
                    link_next      = free_head_reg;
                    free_head_next = pid_rd;
                    wback_next     = 1'b1;
                    hdr_next       = 1'b1;
                    pin_we         = 1'b1;
                    pin_wd         = '0;
                end
            end
            S_TAKE:
            begin
                priority if (pool_room)
                begin
                    cur_next  = used_reg;
                    used_next = used_reg + SIDX_W'(1);
                end
                else if (tail_reg == SENTINEL)
                begin
                    status_next = ST_NO_EVICT;
                end
                else
                begin
                    cur_next     = tail_reg;
                    in_take_next = 1'b1;
                end
            end
            S_LR_RD:
            begin
                lru_ra = cur_reg[SLOT_W-1:0];
            end
            S_LR_W:
            begin
                if (lprev_rd == SENTINEL)
                begin
                    head_next = lnext_rd;
                end
                else
                begin
                    lnext_we = 1'b1;
                    lnext_wa = lprev_rd[SLOT_W-1:0];
                    lnext_wd = lnext_rd;
                end
                if (lnext_rd == SENTINEL)
                begin
                    tail_next = lprev_rd;
                end
                else
                begin
                    lprev_we = 1'b1;
                    lprev_wa = lnext_rd[SLOT_W-1:0];
                    lprev_wd = lprev_rd;
                end
            end
            S_LA1:
            begin
                lnext_we = 1'b1;
                lnext_wd = head_reg;
                lprev_we = 1'b1;
                lprev_wd = SENTINEL;
            end
            S_LA2:
            begin
                if (head_reg != SENTINEL)
                begin
                    lprev_we = 1'b1;
                    lprev_wa = head_reg[SLOT_W-1:0];
                    lprev_wd = cur_reg;
                end
                else
                begin
                    tail_next = cur_reg;
                end
                head_next = cur_reg;
            end
            S_MR_RD:
            begin
                pid_ra   = cur_reg[SLOT_W-1:0];
                chain_ra = cur_reg[SLOT_W-1:0];
            end
            S_MR_B:
            begin
                bkt_next = pid_rd[SLOT_W-1:0];
                cs_next  = chain_rd;
                bkt_ra   = pid_rd[SLOT_W-1:0];
            end
            S_MR_BW:
            begin
                if (bkt_rd == cur_reg)
                begin
                    bkt_we = 1'b1;
                    bkt_wa = bkt_reg;
                    bkt_wd = cs_reg;
                end
                else
                begin
                    p_next   = bkt_rd;
                    chain_ra = bkt_rd[SLOT_W-1:0];
                end
            end
            S_MR_WALK:
            begin
                priority if (chain_rd == cur_reg)
                begin
                    chain_we = 1'b1;
                    chain_wa = p_reg[SLOT_W-1:0];
                    chain_wd = cs_reg;
                end
                else if (chain_rd != NO_SLOT)
                begin
                    p_next   = chain_rd;
                    chain_ra = chain_rd[SLOT_W-1:0];
                end
                else
                begin
                    p_next = p_reg;
                end
            end
            S_TK_INIT:
            begin
                pid_we = 1'b1;
                pid_wd = key_reg;
                pin_we = 1'b1;
                pin_wd = PIN_ONE;
                wr_we  = 1'b1;
                wr_wd  = req_reg.req_type != REQ_GET;
                bkt_ra = key_reg[SLOT_W-1:0];
            end
            S_MA_W:
            begin
                chain_we   = 1'b1;
                chain_wd   = bkt_rd;
                bkt_we     = 1'b1;
                bkt_wa     = key_reg[SLOT_W-1:0];
                bkt_wd     = cur_reg;
                rslot_next = cur_reg;
                priority if (req_reg.req_type != REQ_ALLOC)
                begin
                    fill_next = 1'b1;
                end
                else if (free_head_reg != '0)
                begin
                    fill_next      = 1'b1;
                    free_head_next = req_reg.next_free_id;
                end
                else
                begin
                    append_next     = 1'b1;
                    page_count_next = page_count_reg + ID_W'(1);
                end
            end
            S_FIN:
            begin
                pid_ra = rslot_reg[SLOT_W-1:0];
                pin_ra = rslot_reg[SLOT_W-1:0];
            end
            S_OUT:
            begin
                pid_ra    = rslot_reg[SLOT_W-1:0];
                pin_ra    = rslot_reg[SLOT_W-1:0];
                res_valid = 1'b1;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PAGE_COUNT: page_count_next = cfg_data;
                CFG_FREE_HEAD:  free_head_next  = cfg_data;
                default:        page_count_next = page_count_next;
            endcase
        end
    end

    always_comb
    begin
        res.status         = status_reg;
        res.fill_from_disk = fill_reg;
        res.append_to_file = append_reg;
        res.write_back     = wback_reg;
        res.header_write   = hdr_reg;
        res.link_to_store  = link_reg;
        res.free_head      = free_head_reg;
        res.page_count     = page_count_reg;
        if (rslot_reg == NO_SLOT)
        begin
            res.result_slot    = '0;
            res.result_page_id = '0;
            res.pin_count      = '0;
        end
        else
        begin
            res.result_slot    = rslot_reg[SLOT_W-1:0];
            res.result_page_id = pid_rd;
            res.pin_count      = pin_rd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            clr_reg        <= '0;
            used_reg       <= '0;
            head_reg       <= SENTINEL;
            tail_reg       <= SENTINEL;
            free_head_reg  <= '0;
            page_count_reg <= ID_W'(1);
            in_take_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            used_reg       <= used_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            free_head_reg  <= free_head_next;
            page_count_reg <= page_count_next;
            in_take_reg    <= in_take_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        cur_reg    <= cur_next;
        rslot_reg  <= rslot_next;
        p_reg      <= p_next;
        cs_reg     <= cs_next;
        bkt_reg    <= bkt_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        fill_reg   <= fill_next;
        append_reg <= append_next;
        wback_reg  <= wback_next;
        hdr_reg    <= hdr_next;
        link_reg   <= link_next;
    end

endmodule

// ===== hw/rtl/page_buffer_pool_manager_unit.sv =====
// Page buffer pool directory. One request word in gives one result word out. Requests are
// handled one at a time by a sequencer over directory memories with one read and one write
// port each: a request occupies the sequencer from acceptance until its result is handed
// on, for longer with each hash-chain entry compared, and an eviction also walks the
// victim's hash chain to unlink it. After reset a clearing pass over the bucket table runs
// before the first request is accepted; configuration writes are taken at any time the
// block is idle. A finished result waits in the output register so the next request can be
// taken meanwhile.
module page_buffer_pool_manager_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pbpm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pbpm_pkg::ID_W-1:0]         cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // req_type, page_id, slot, next_free_id
    input  logic [pbpm_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status, result_slot, result_page_id, fill_from_disk, append_to_file, write_back,
    // header_write, link_to_store, pin_count, free_head, page_count
    output logic [pbpm_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import pbpm_pkg::*;

    pbpm_req_t    req;
    pbpm_result_t res;
    logic         res_valid, res_ready;
    logic         out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    assign req       = pbpm_req_t'(s_tdata[REQ_W-1:0]);
    assign res_ready = !out_valid_reg || m_tready;

    pbpm_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_data_next = OUT_DATA_W'(res);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== hw/rtl/pbpm_checker.sv =====
module pbpm_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [pbpm_pkg::OUT_DATA_W-1:0] m_tdata
);
    import pbpm_pkg::*;

    pbpm_result_t r;

    assign r = pbpm_result_t'(m_tdata[RES_W-1:0]);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (r.status == ST_NO_EVICT || r.status == ST_BAD_ID)
        |-> r.result_slot == '0 && r.pin_count == '0 && !r.fill_from_disk
            && !r.append_to_file)
        else $error("failed load reports a slot");

    a_delete: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && r.header_write
        |-> r.write_back && r.status == ST_OK && r.pin_count == '0)
        else $error("delete result inconsistent");

    a_append: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && r.append_to_file
        |-> r.status == ST_OK && r.pin_count == PIN_ONE && !r.fill_from_disk)
        else $error("append result inconsistent");

endmodule

bind page_buffer_pool_manager_unit pbpm_checker u_pbpm_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== dv/page_buffer_pool_manager_unit_tb.sv =====
`timescale 1ns / 1ps

module page_buffer_pool_manager_unit_tb;
    import pbpm_pkg::*;

    localparam int STALL_LIMIT = 40000;
    localparam int NOS = SLOTS;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ID_W-1:0] cfg_data;
    logic s_tvalid;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    page_buffer_pool_manager_unit dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    pbpm_req_t    pending_reqs[$];
    pbpm_result_t expected_results[$];
    int errors;
    int idle_cycles;
    int results_seen;

    // directory mirror
    logic [ID_W-1:0]     pg_of[NOS];
    logic [PIN_BITS-1:0] pins[NOS];
    logic                wr_flag[NOS];
    int                  bucket[NOS];
    int                  chain[NOS];
    int                  lru_nx[NOS+1];
    int                  lru_pv[NOS+1];
    int                  used_slots;
    logic [ID_W-1:0]     free_hd;
    logic [ID_W-1:0]     page_cnt;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic void lru_link(int s);
        int first;
        first = lru_nx[NOS];
        lru_nx[s] = first;
        lru_pv[s] = NOS;
        lru_pv[first] = s;
        lru_nx[NOS] = s;
    endfunction

    function automatic void lru_unlink(int s);
        int p;
        int n;
        p = lru_pv[s];
        n = lru_nx[s];
        lru_nx[p] = n;
        lru_pv[n] = p;
    endfunction

    function automatic int lookup_page(logic [ID_W-1:0] id);
        int s;
        int guard;
        s = bucket[id % NOS];
        guard = 0;
        while (s != NOS && pg_of[s] != id && guard <= NOS)
        begin
            s = chain[s];
            guard++;
        end
        return (guard > NOS) ? NOS : s;
    endfunction

    function automatic void hash_insert(int s);
        int b;
        b = pg_of[s] % NOS;
        chain[s] = bucket[b];
        bucket[b] = s;
    endfunction

    function automatic void hash_unlink(int s);
        int b;
        int p;
        int guard;
        b = pg_of[s] % NOS;
        p = bucket[b];
        guard = 0;
        if (p == s)
        begin
            bucket[b] = chain[s];
            return;
        end
        while (p != NOS && chain[p] != s && guard <= NOS)
        begin
            p = chain[p];
            guard++;
        end
        if (p != NOS && guard <= NOS)
            chain[p] = chain[s];
    endfunction

    function automatic int claim_slot(logic [ID_W-1:0] id);
        int s;
        if (used_slots < NOS)
        begin
            s = used_slots;
            used_slots++;
        end
        else
        begin
            s = lru_pv[NOS];
            if (s == NOS)
                return NOS;
            lru_unlink(s);
            hash_unlink(s);
        end
        pg_of[s] = id;
        pins[s] = PIN_ONE;
        wr_flag[s] = 1'b0;
        hash_insert(s);
        return s;
    endfunction

    function automatic void drop_pin(int s);
        pins[s] = pins[s] - 1'b1;
        if (pins[s] == '0)
            lru_link(s);
    endfunction

    function automatic logic [STAT_W-1:0] pin_page(logic [ID_W-1:0] id, inout int s,
                                                   inout logic fill);
        int h;
        if (id == 0 || id >= page_cnt)
            return ST_BAD_ID;
        h = lookup_page(id);
        if (h != NOS)
        begin
            s = h;
            if (wr_flag[h])
                return ST_WR_LOCK;
            if (pins[h] == '0)
                lru_unlink(h);
            if (pins[h] != PIN_MAX)
                pins[h] = pins[h] + 1'b1;
            return ST_OK;
        end
        h = claim_slot(id);
        if (h == NOS)
            return ST_NO_EVICT;
        s = h;
        fill = 1'b1;
        return ST_OK;
    endfunction

    function automatic pbpm_result_t directory_step(pbpm_req_t r);
        pbpm_result_t res;
        int s;
        int h;
        logic fill;
        res = '0;
        s = NOS;
        fill = 1'b0;
        res.status = ST_OK;
        case (r.req_type)
            REQ_GET:
                res.status = pin_page(r.page_id, s, fill);
            REQ_GET_WR:
            begin
                res.status = pin_page(r.page_id, s, fill);
                if (res.status == ST_OK)
                begin
                    if (pins[s] != PIN_ONE)
                    begin
                        drop_pin(s);
                        res.status = ST_PINS;
                    end
                    else
                        wr_flag[s] = 1'b1;
                end
            end
            REQ_MAKE_WR, REQ_RELEASE, REQ_DELETE:
            begin
                if (!(int'(r.slot) < used_slots && pins[r.slot] != '0))
                    res.status = ST_NOT_HELD;
                else
                begin
                    s = r.slot;
                    if (r.req_type == REQ_RELEASE)
                    begin
                        drop_pin(s);
                        if (wr_flag[s])
                        begin
                            wr_flag[s] = 1'b0;
                            res.write_back = 1'b1;
                        end
                    end
                    else if (pins[s] != PIN_ONE)
                        res.status = ST_PINS;
                    else if (r.req_type == REQ_MAKE_WR)
                        wr_flag[s] = 1'b1;
                    else
                    begin
                        res.link_to_store = free_hd;
                        free_hd = pg_of[s];
                        res.write_back = 1'b1;
                        res.header_write = 1'b1;
                        drop_pin(s);
                    end
                end
            end
            REQ_ALLOC:
            begin
                if (free_hd != 0)
                begin
                    h = lookup_page(free_hd);
                    if (h != NOS)
                    begin
                        s = h;
                        if (pins[h] != '0)
                            res.status = ST_PINS;
                        else
                        begin
                            lru_unlink(h);
                            pins[h] = PIN_ONE;
                        end
                    end
                    else
                    begin
                        h = claim_slot(free_hd);
                        if (h == NOS)
                            res.status = ST_NO_EVICT;
                        else
                        begin
                            s = h;
                            fill = 1'b1;
                        end
                    end
                    if (res.status == ST_OK)
                        free_hd = r.next_free_id;
                end
                else if (page_cnt == 0 || page_cnt == '1)
                    res.status = ST_BAD_ID;
                else
                begin
                    h = claim_slot(page_cnt);
                    if (h == NOS)
                        res.status = ST_NO_EVICT;
                    else
                    begin
                        s = h;
                        page_cnt = page_cnt + 1;
                        res.append_to_file = 1'b1;
                    end
                end
                if (res.status == ST_OK)
                    wr_flag[s] = 1'b1;
            end
            default:
            begin
            end
        endcase
        if (s != NOS)
        begin
            res.result_slot = s[SLOT_W-1:0];
            res.result_page_id = pg_of[s];
            res.pin_count = pins[s];
        end
        res.fill_from_disk = fill;
        res.free_head = free_hd;
        res.page_count = page_cnt;
        return res;
    endfunction

    task automatic send(logic [2:0] kind, logic [ID_W-1:0] id, logic [SLOT_W-1:0] s,
                        logic [ID_W-1:0] nxt);
        pbpm_req_t r;
        r.req_type = kind;
        r.page_id = id;
        r.slot = s;
        r.next_free_id = nxt;
        expected_results.push_back(directory_step(r));
        pending_reqs.push_back(r);
    endtask

    task automatic drain();
        wait (pending_reqs.size() == 0 && expected_results.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ID_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == CFG_PAGE_COUNT)
            page_cnt = val;
        else
            free_hd = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [SLOT_W-1:0] held_slot();
        int cand[$];
        for (int i = 0; i < used_slots; i++)
            if (pins[i] != '0 && pins[i] < 16'd100)
                cand.push_back(i);
        if (cand.size() == 0)
            return SLOT_W'($urandom_range(0, NOS - 1));
        return SLOT_W'(cand[$urandom_range(0, cand.size() - 1)]);
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        case ($urandom_range(0, 3))
            0: return ID_W'($urandom_range(1, 40));
            1: return ID_W'($urandom_range(1, 4) * NOS + $urandom_range(1, 6));
            2: return ID_W'($urandom_range(1, 1500));
            default: return ID_W'($urandom_range(1, 8));
        endcase
    endfunction

    // sender: bursts of words with gaps
    int burst_left;
    int gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                s_tdata <= IN_DATA_W'(pending_reqs.pop_front());
                s_tvalid <= 1'b1;
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver: own stall pattern, one long hold-off
    int stall_left;
    int ready_left;
    bit long_done;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left <= 0;
            ready_left <= 0;
            long_done <= 1'b0;
        end
        else if (!long_done && results_seen >= 300)
        begin
            long_done <= 1'b1;
            m_tready <= 1'b0;
            stall_left <= 400;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (ready_left > 0)
        begin
            ready_left <= ready_left - 1;
            m_tready <= 1'b1;
        end
        else
        begin
            ready_left <= $urandom_range(1, 40);
            stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            m_tready <= 1'b1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        pbpm_result_t got;
        pbpm_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[RES_W-1:0];
            results_seen++;
            if (expected_results.size() == 0)
                report("unexpected word", got.status, 0);
            else
            begin
                want = expected_results.pop_front();
                if (got.status !== want.status)
                    report("status", got.status, want.status);
                if (got.result_slot !== want.result_slot)
                    report("result_slot", got.result_slot, want.result_slot);
                if (got.result_page_id !== want.result_page_id)
                    report("result_page_id", got.result_page_id, want.result_page_id);
                if (got.fill_from_disk !== want.fill_from_disk)
                    report("fill_from_disk", got.fill_from_disk, want.fill_from_disk);
                if (got.append_to_file !== want.append_to_file)
                    report("append_to_file", got.append_to_file, want.append_to_file);
                if (got.write_back !== want.write_back)
                    report("write_back", got.write_back, want.write_back);
                if (got.header_write !== want.header_write)
                    report("header_write", got.header_write, want.header_write);
                if (got.link_to_store !== want.link_to_store)
                    report("link_to_store", got.link_to_store, want.link_to_store);
                if (got.pin_count !== want.pin_count)
                    report("pin_count", got.pin_count, want.pin_count);
                if (got.free_head !== want.free_head)
                    report("free_head", got.free_head, want.free_head);
                if (got.page_count !== want.page_count)
                    report("page_count", got.page_count, want.page_count);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [ID_W-1:0] id;
        int k;
        errors = 0;
        idle_cycles = 0;
        results_seen = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        m_tready = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        for (int i = 0; i < NOS; i++)
        begin
            pg_of[i] = '0;
            pins[i] = '0;
            wr_flag[i] = 1'b0;
            chain[i] = 0;
            bucket[i] = NOS;
            lru_nx[i] = 0;
            lru_pv[i] = 0;
        end
        lru_nx[NOS] = NOS;
        lru_pv[NOS] = NOS;
        used_slots = 0;
        free_hd = '0;
        page_cnt = 1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset values: only id 0 exists, allocate extends the file
        send(REQ_GET, 1, 0, 0);
        send(REQ_ALLOC, 0, 0, 0);
        send(REQ_RELEASE, 0, 0, 0);
        drain();
        write_reg(CFG_PAGE_COUNT, 50);
        write_reg(CFG_FREE_HEAD, 0);
        send(REQ_GET, 0, 0, 0);
        send(REQ_GET, 50, 0, 0);
        send(REQ_GET, '1, '1, '1);
        send(REQ_GET, 3, 0, 0);
        send(REQ_GET, 3, 0, 0);
        send(REQ_GET_WR, 3, 0, 0);
        send(REQ_MAKE_WR, 0, 1, 0);
        send(REQ_GET_WR, 7, 0, 0);
        send(REQ_GET, 7, 0, 0);
        send(REQ_MAKE_WR, 0, 2, 0);
        send(REQ_RELEASE, 0, 2, 0);
        send(REQ_MAKE_WR, 0, 1023, 0);
        send(REQ_RELEASE, 0, 1023, 0);
        send(REQ_DELETE, 0, 1, 0);
        send(REQ_RELEASE, 0, 1, 0);
        send(REQ_DELETE, 0, 1, 0);
        send(REQ_ALLOC, 0, 0, 0);
        send(REQ_ALLOC, 0, 0, 30);
        send(REQ_DELETE, 0, 1023, 0);
        send(3'd6, '1, '1, '1);
        send(3'd7, 12, 5, 9);
        drain();

        // fill the pool until loads find nothing to evict
        write_reg(CFG_PAGE_COUNT, 3000);
        for (int i = 1; i <= NOS + 1; i++)
            send(REQ_GET, ID_W'(i), 0, 0);
        send(REQ_ALLOC, 0, 0, 0);
        drain();
        write_reg(CFG_FREE_HEAD, 2500);
        send(REQ_ALLOC, 0, 0, 7);
        drain();

        // random traffic
        write_reg(CFG_FREE_HEAD, 0);
        write_reg(CFG_PAGE_COUNT, 5000);
        for (int n = 0; n < 200; n++)
        begin
            k = $urandom_range(0, 99);
            if (k < 35)
                send(REQ_GET, pick_id(), SLOT_W'($urandom), $urandom);
            else if (k < 45)
                send(REQ_GET_WR, pick_id(), SLOT_W'($urandom), $urandom);
            else if (k < 52)
                send(REQ_MAKE_WR, $urandom, held_slot(), $urandom);
            else if (k < 77)
                send(REQ_RELEASE, $urandom, held_slot(), $urandom);
            else if (k < 85)
                send(REQ_ALLOC, $urandom, SLOT_W'($urandom),
                     ($urandom_range(0, 1) == 0) ? 0 : pick_id());
            else if (k < 93)
                send(REQ_DELETE, $urandom, held_slot(), $urandom);
            else
                send(3'($urandom_range(0, 7)), $urandom, SLOT_W'($urandom), $urandom);
            if (n == 100)
                drain();
        end
        drain();

        // extremes of the registers and full-width ids
        write_reg(CFG_PAGE_COUNT, '1);
        write_reg(CFG_FREE_HEAD, '1);
        send(REQ_ALLOC, 0, 0, 0);
        send(REQ_ALLOC, 0, 0, 0);
        for (int i = 0; i < 30; i++)
        begin
            id = $urandom;
            send(($urandom_range(0, 1) == 0) ? REQ_GET : REQ_RELEASE, id, held_slot(),
                 $urandom);
        end
        drain();
        write_reg(CFG_PAGE_COUNT, 1);
        send(REQ_GET, 1, 0, 0);
        drain();

        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/pbpm_pkg.sv
hw/rtl/pbpm_core.sv
hw/rtl/page_buffer_pool_manager_unit.sv
hw/rtl/pbpm_checker.sv
dv/page_buffer_pool_manager_unit_tb.sv
